### src/psp_pkg.sv
// package for the psi section parser: shared types and constants
// no dependencies
package psp_pkg;

  localparam int unsigned PID_TABLE_DEPTH_DEF = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PROG_W   = 16;
  localparam int unsigned PID_W    = 13;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] TID_PAT = 8'h00;
  localparam logic [BYTE_W-1:0] TID_PMT = 8'h02;

  localparam logic [BYTE_W-1:0] VIDEO_TYPE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] AUDIO_TYPE_RST = 8'h03;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIDEO_TYPE = 4'd0,
    CFG_AUDIO_TYPE = 4'd1
  } psp_cfg_idx_e;

  typedef enum logic [2:0] {
    SEC_IDLE = 3'b001,
    SEC_PAT  = 3'b010,
    SEC_PMT  = 3'b100
  } psp_sec_e;

  typedef enum logic {
    REC_PAT = 1'b0,
    REC_PMT = 1'b1
  } psp_rec_e;

  // one finished entry out of the parser
  typedef struct packed {
    logic              fire;
    psp_rec_e          kind;
    logic [PROG_W-1:0] prog;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] stream;
    logic [LEN_W-1:0]  es_len;
  } psp_entry_t;

  // insert outcome of one pid table
  typedef struct packed {
    logic added;
    logic full;
  } psp_ins_t;

  typedef struct packed {
    psp_rec_e              record_kind;
    logic [PROG_W-1:0]     prog_num;
    logic [PID_W-1:0]      pid;
    logic [BYTE_W-1:0]     stream_kind;
    logic [LEN_W-1:0]      descriptor_length;
    logic                  video_added;
    logic                  audio_added;
    logic                  table_full;
    logic [SLOT_OUT_W-1:0] slot_index;
  } psp_result_t;

endpackage

### src/psp_chan_if.sv
// channel interfaces of the psi section parser: input, result and config
// depends on psp_pkg
interface psp_in_chan_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;
  modport source (output valid, output data_byte, output section_start, input ready);
  modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

interface psp_out_chan_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] prog_num;
  logic [12:0] pid;
  logic [7:0]  stream_kind;
  logic [11:0] descriptor_length;
  logic        video_added;
  logic        audio_added;
  logic        table_full;
  logic [2:0]  slot_index;
  modport source (output valid, output record_kind, output prog_num, output pid,
                  output stream_kind, output descriptor_length, output video_added,
                  output audio_added, output table_full, output slot_index,
                  input ready);
  modport sink   (input valid, input record_kind, input prog_num, input pid,
                  input stream_kind, input descriptor_length, input video_added,
                  input audio_added, input table_full, input slot_index,
                  output ready);
endinterface

interface psp_cfg_chan_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/psp_parser.sv
// byte-serial section parser: tracks position, lengths and entry bytes
// depends on psp_pkg
module psp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [psp_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       section_start_i,
  output psp_pkg::psp_entry_t        entry_o
);
  import psp_pkg::*;

  localparam logic [LEN_W-1:0] POS_LEN_HI  = 12'd1;
  localparam logic [LEN_W-1:0] POS_LEN_LO  = 12'd2;
  localparam logic [LEN_W-1:0] POS_PROG_HI = 12'd3;
  localparam logic [LEN_W-1:0] POS_PROG_LO = 12'd4;
  localparam logic [LEN_W-1:0] POS_PAT_LOOP = 12'd8;
  localparam logic [LEN_W-1:0] POS_INFO_HI = 12'd10;
  localparam logic [LEN_W-1:0] POS_INFO_LO = 12'd11;
  localparam logic [LEN_W-1:0] POS_MAX     = 12'hFFF;
  localparam logic [2:0]       PAT_LAST    = 3'd3;
  localparam logic [2:0]       PMT_LAST    = 3'd4;

  psp_sec_e          kind_q, kind_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  info_q, info_d;
  logic [PROG_W-1:0] prog_q, prog_d;
  logic [39:0]       ent_q, ent_d;
  logic [2:0]        phase_q, phase_d;
  logic [LEN_W-1:0]  skip_q, skip_d;
  logic [39:0]       shifted;
  logic [LEN_W-1:0]  info_full;
  logic              past_loop;

  assign shifted   = {ent_q[31:0], data_byte_i};
  assign info_full = info_q | {4'h0, data_byte_i};
  assign past_loop = ({1'b0, pos_q} + 13'd1) >= {1'b0, len_q};

  always_comb begin
    kind_d  = kind_q;
    pos_d   = pos_q;
    len_d   = len_q;
    info_d  = info_q;
    prog_d  = prog_q;
    ent_d   = ent_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    entry_o = '0;
    entry_o.prog = prog_q;
    if (accept_i) begin
      if (section_start_i) begin
        kind_d  = (data_byte_i == TID_PAT) ? SEC_PAT :
                  (data_byte_i == TID_PMT) ? SEC_PMT : SEC_IDLE;
        pos_d   = POS_LEN_HI;
        len_d   = '0;
        info_d  = '0;
        prog_d  = '0;
        ent_d   = '0;
        phase_d = '0;
        skip_d  = '0;
      end else if (kind_q != SEC_IDLE) begin
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + 12'd1;
        end
        if (pos_q == POS_LEN_HI) begin
          len_d = {data_byte_i[3:0], 8'h00};
        end else if (pos_q == POS_LEN_LO) begin
          len_d = len_q | {4'h0, data_byte_i};
        end else if (pos_q == POS_PROG_HI) begin
          prog_d = {data_byte_i, 8'h00};
        end else if (pos_q == POS_PROG_LO) begin
          prog_d = {prog_q[15:8], data_byte_i};
        end else if (past_loop) begin
          // crc and trailing bytes
        end else if (kind_q == SEC_PAT) begin
          if (pos_q >= POS_PAT_LOOP) begin
            ent_d   = shifted;
            phase_d = phase_q + 3'd1;
            if (phase_q == PAT_LAST) begin
              phase_d       = '0;
              entry_o.fire  = 1'b1;
              entry_o.kind  = REC_PAT;
              entry_o.prog  = shifted[31:16];
              entry_o.pid   = shifted[12:0];
            end
          end
        end else begin
          if (pos_q < POS_INFO_HI) begin
            // fixed header bytes
          end else if (pos_q == POS_INFO_HI) begin
            info_d = {data_byte_i[3:0], 8'h00};
          end else if (pos_q == POS_INFO_LO) begin
            info_d = info_full;
            skip_d = info_full;
          end else if (skip_q != '0) begin
            skip_d = skip_q - 12'd1;
          end else begin
            ent_d   = shifted;
            phase_d = phase_q + 3'd1;
            if (phase_q == PMT_LAST) begin
              phase_d        = '0;
              skip_d         = shifted[11:0];
              entry_o.fire   = 1'b1;
              entry_o.kind   = REC_PMT;
              entry_o.pid    = shifted[28:16];
              entry_o.stream = shifted[39:32];
              entry_o.es_len = shifted[11:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= SEC_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      info_q  <= '0;
      prog_q  <= '0;
      ent_q   <= '0;
      phase_q <= '0;
      skip_q  <= '0;
    end else begin
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      info_q  <= info_d;
      prog_q  <= prog_d;
      ent_q   <= ent_d;
      phase_q <= phase_d;
      skip_q  <= skip_d;
    end
  end

endmodule

### src/psp_pid_table.sv
// deduplicating pid table with per-slot valid bits
// depends on psp_pkg
module psp_pid_table #(
  parameter int unsigned Depth = psp_pkg::PID_TABLE_DEPTH_DEF,
  parameter int unsigned SlotW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_i,
  input  logic [psp_pkg::PID_W-1:0] pid_i,
  output psp_pkg::psp_ins_t         ins_o,
  output logic [SlotW-1:0]          slot_o
);
  import psp_pkg::*;

  logic [PID_W-1:0] pid_q [Depth];
  logic [Depth-1:0] valid_q, valid_d;
  logic             hit;
  logic             free_found;
  logic [SlotW-1:0] free_slot;

  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < Depth; i++) begin
      if (valid_q[i]) begin
        if (pid_q[i] == pid_i) begin
          hit = 1'b1;
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
    ins_o.added = req_i && !hit && free_found;
    ins_o.full  = req_i && !hit && !free_found;
    slot_o      = free_slot;
    valid_d     = valid_q;
    if (ins_o.added) begin
      valid_d[free_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_o.added) begin
      pid_q[free_slot] <= pid_i;
    end
  end

endmodule

### src/psp_out_buf.sv
// result register with a skid stage behind it
// depends on psp_pkg
module psp_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  psp_pkg::psp_result_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output psp_pkg::psp_result_t data_o
);
  import psp_pkg::*;

  logic        out_v_q, out_v_d;
  logic        skid_v_q, skid_v_d;
  psp_result_t out_q, out_d;
  psp_result_t skid_q, skid_d;
  logic        pop;

  assign pop     = out_v_q && ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q || pop) begin
        out_d   = data_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

### src/psi_section_parser_core.sv
// top level of the psi section parser: parser, two pid tables, result buffer
// depends on psp_pkg, psp_chan_if, psp_parser, psp_pid_table, psp_out_buf
//
//   channel    dir  payload                                        accepted when
//   in_chan    in   data_byte, section_start                       valid && ready
//   out_chan   out  record_kind .. slot_index (one result record)  valid && ready
//   cfg_chan   in   index, data (type codes)                       valid && ready
//
// one byte per cycle while ready is high; each byte is parsed and the table lookup done in the
// cycle it is accepted, its result is registered at that edge, in the output
// register or, when that one is stalled, in the skid stage behind it
// a byte can be accepted while a result waits; ready drops only when both the
// output register and the skid stage hold results
// reset clears parser state and table valid bits at once; config is always ready
module psi_section_parser_core #(
  parameter int unsigned PID_TABLE_DEPTH = psp_pkg::PID_TABLE_DEPTH_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  psp_in_chan_if.sink    in_chan,
  psp_out_chan_if.source out_chan,
  psp_cfg_chan_if.sink   cfg_chan
);
  import psp_pkg::*;

  localparam int unsigned SlotW = (PID_TABLE_DEPTH > 1) ? $clog2(PID_TABLE_DEPTH) : 1;

  logic              accept;
  logic              buf_ready;
  psp_entry_t        entry;
  logic [BYTE_W-1:0] video_code_q, audio_code_q;
  logic              video_req, audio_req;
  psp_ins_t          video_ins, audio_ins;
  logic [SlotW-1:0]  video_slot, audio_slot;
  logic [SlotW+2:0]  video_slot_ext, audio_slot_ext;
  psp_result_t       result, out_data;

  assign accept       = in_chan.valid && buf_ready;
  assign in_chan.ready = buf_ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_code_q <= VIDEO_TYPE_RST;
      audio_code_q <= AUDIO_TYPE_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_VIDEO_TYPE: video_code_q <= cfg_chan.data;
        CFG_AUDIO_TYPE: audio_code_q <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  psp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (in_chan.data_byte),
    .section_start_i (in_chan.section_start),
    .entry_o         (entry)
  );

  assign video_req = entry.fire && (entry.kind == REC_PMT) && (entry.stream == video_code_q);
  assign audio_req = entry.fire && (entry.kind == REC_PMT) && (entry.stream == audio_code_q);

  psp_pid_table #(.Depth(PID_TABLE_DEPTH), .SlotW(SlotW)) u_video_tab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (video_req),
    .pid_i  (entry.pid),
    .ins_o  (video_ins),
    .slot_o (video_slot)
  );

  psp_pid_table #(.Depth(PID_TABLE_DEPTH), .SlotW(SlotW)) u_audio_tab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (audio_req),
    .pid_i  (entry.pid),
    .ins_o  (audio_ins),
    .slot_o (audio_slot)
  );

  assign video_slot_ext = {3'b000, video_slot};
  assign audio_slot_ext = {3'b000, audio_slot};

  always_comb begin
    result.record_kind       = entry.kind;
    result.prog_num          = entry.prog;
    result.pid               = entry.pid;
    result.stream_kind       = entry.stream;
    result.descriptor_length = entry.es_len;
    result.video_added       = video_ins.added;
    result.audio_added       = audio_ins.added;
    result.table_full        = video_ins.full || audio_ins.full;
    result.slot_index        = video_ins.added ? video_slot_ext[SLOT_OUT_W-1:0] :
                               audio_ins.added ? audio_slot_ext[SLOT_OUT_W-1:0] :
                               '0;
  end

  psp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (entry.fire),
    .data_i  (result),
    .ready_o (buf_ready),
    .valid_o (out_chan.valid),
    .ready_i (out_chan.ready),
    .data_o  (out_data)
  );

  assign out_chan.record_kind       = out_data.record_kind;
  assign out_chan.prog_num          = out_data.prog_num;
  assign out_chan.pid               = out_data.pid;
  assign out_chan.stream_kind       = out_data.stream_kind;
  assign out_chan.descriptor_length = out_data.descriptor_length;
  assign out_chan.video_added       = out_data.video_added;
  assign out_chan.audio_added       = out_data.audio_added;
  assign out_chan.table_full        = out_data.table_full;
  assign out_chan.slot_index        = out_data.slot_index;

endmodule

### src/psp_checker.sv
// port-level checks of the psi section parser, bound to the top level
// depends on psi_section_parser_core
module psp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        record_kind,
  input logic [15:0] prog_num,
  input logic [12:0] pid,
  input logic [7:0]  stream_kind,
  input logic [11:0] descriptor_length,
  input logic        video_added,
  input logic        audio_added,
  input logic        table_full,
  input logic [2:0]  slot_index
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pid) && $stable(prog_num)
      && $stable(record_kind) && $stable(slot_index))
    else $error("stalled result changed");

  // pat records carry no stream info and no table activity
  a_pat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !record_kind |-> stream_kind == 8'h00 && descriptor_length == 12'h000
      && !video_added && !audio_added && !table_full && slot_index == 3'd0)
    else $error("pat record with pmt fields set");

  // a slot is only reported when a pid was added
  a_slot_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && slot_index != 3'd0 |-> video_added || audio_added)
    else $error("slot index without add");

  // input back-pressure only after a stalled result
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input stalled without a waiting result");

endmodule

bind psi_section_parser_core psp_checker u_psp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .record_kind       (out_chan.record_kind),
  .prog_num          (out_chan.prog_num),
  .pid               (out_chan.pid),
  .stream_kind       (out_chan.stream_kind),
  .descriptor_length (out_chan.descriptor_length),
  .video_added       (out_chan.video_added),
  .audio_added       (out_chan.audio_added),
  .table_full        (out_chan.table_full),
  .slot_index        (out_chan.slot_index)
);

### sim/psp_result_checker.sv
// result checker for the psi section parser: watches the input, config and result channels,
// predicts each result record and compares it field by field with what the block returns
// depends on psp_pkg and psp_chan_if
module psp_result_checker #(
  parameter int unsigned PID_TABLE_DEPTH = psp_pkg::PID_TABLE_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  psp_in_chan_if  in_chan,
  psp_out_chan_if out_chan,
  psp_cfg_chan_if cfg_chan,
  output int      fail_count_o,
  output int      pending_o
);
  import psp_pkg::*;

  logic [BYTE_W-1:0] video_code;
  logic [BYTE_W-1:0] audio_code;

  psp_sec_e          sec_kind;
  logic [LEN_W-1:0]  byte_pos;
  logic [LEN_W-1:0]  sec_len;
  logic [LEN_W-1:0]  info_len;
  logic [LEN_W-1:0]  skip_left;
  logic [PROG_W-1:0] cur_prog;
  logic [39:0]       entry_sr;
  logic [2:0]        entry_cnt;

  logic [PID_W-1:0]           video_pids [PID_TABLE_DEPTH];
  logic [PID_TABLE_DEPTH-1:0] video_used;
  logic [PID_W-1:0]           audio_pids [PID_TABLE_DEPTH];
  logic [PID_TABLE_DEPTH-1:0] audio_used;

  psp_result_t entry_q[$];
  psp_result_t want;
  psp_result_t got;
  psp_result_t nxt;
  logic        nxt_hit;
  int          fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic store_pid(input logic to_video, input logic [PID_W-1:0] pid_v,
                           output psp_ins_t res, output logic [SLOT_OUT_W-1:0] slot);
    int               free_i;
    logic             present;
    logic             used;
    logic [PID_W-1:0] cur;
    free_i  = -1;
    present = 1'b0;
    res     = '0;
    slot    = '0;
    for (int i = 0; i < PID_TABLE_DEPTH; i++) begin
      used = to_video ? video_used[i] : audio_used[i];
      cur  = to_video ? video_pids[i] : audio_pids[i];
      if (used) begin
        if (cur == pid_v) present = 1'b1;
      end else if (free_i < 0) begin
        free_i = i;
      end
    end
    if (!present) begin
      if (free_i < 0) begin
        res.full = 1'b1;
      end else begin
        res.added = 1'b1;
        slot      = free_i[SLOT_OUT_W-1:0];
        if (to_video) begin
          video_pids[free_i] = pid_v;
          video_used[free_i] = 1'b1;
        end else begin
          audio_pids[free_i] = pid_v;
          audio_used[free_i] = 1'b1;
        end
      end
    end
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic start,
                            output logic hit, output psp_result_t r);
    int unsigned           p;
    logic [BYTE_W-1:0]     st;
    logic [PID_W-1:0]      epid;
    logic [LEN_W-1:0]      es;
    psp_ins_t              vres;
    psp_ins_t              ares;
    logic [SLOT_OUT_W-1:0] vslot;
    logic [SLOT_OUT_W-1:0] aslot;
    hit   = 1'b0;
    r     = '0;
    vres  = '0;
    ares  = '0;
    vslot = '0;
    aslot = '0;
    if (start) begin
      if (b == TID_PAT) sec_kind = SEC_PAT;
      else if (b == TID_PMT) sec_kind = SEC_PMT;
      else sec_kind = SEC_IDLE;
      byte_pos  = 1;
      sec_len   = '0;
      info_len  = '0;
      cur_prog  = '0;
      entry_sr  = '0;
      entry_cnt = '0;
      skip_left = '0;
    end else if (sec_kind != SEC_IDLE) begin
      p = byte_pos;
      if (byte_pos != {LEN_W{1'b1}}) byte_pos = byte_pos + 1'b1;
      case (p)
        1: sec_len = {b[3:0], 8'h00};
        2: sec_len = {sec_len[11:8], b};
        3: cur_prog = {b, 8'h00};
        4: cur_prog = {cur_prog[15:8], b};
        default: begin
          if (p + 1 < sec_len) begin
            if (sec_kind == SEC_PAT) begin
              if (p >= 8) begin
                entry_sr  = {entry_sr[31:0], b};
                entry_cnt = entry_cnt + 1'b1;
                if (entry_cnt == 4) begin
                  entry_cnt     = '0;
                  hit           = 1'b1;
                  r.record_kind = REC_PAT;
                  r.prog_num    = entry_sr[31:16];
                  r.pid         = entry_sr[12:0];
                end
              end
            end else if (p == 10) begin
              info_len = {b[3:0], 8'h00};
            end else if (p == 11) begin
              info_len  = {info_len[11:8], b};
              skip_left = info_len;
            end else if (p > 11) begin
              if (skip_left != 0) begin
                skip_left = skip_left - 1'b1;
              end else begin
                entry_sr  = {entry_sr[31:0], b};
                entry_cnt = entry_cnt + 1'b1;
                if (entry_cnt == 5) begin
                  entry_cnt = '0;
                  st        = entry_sr[39:32];
                  epid      = entry_sr[28:16];
                  es        = entry_sr[11:0];
                  skip_left = es;
                  if (st == video_code) store_pid(1'b1, epid, vres, vslot);
                  if (st == audio_code) store_pid(1'b0, epid, ares, aslot);
                  hit                 = 1'b1;
                  r.record_kind       = REC_PMT;
                  r.prog_num          = cur_prog;
                  r.pid               = epid;
                  r.stream_kind       = st;
                  r.descriptor_length = es;
                  r.video_added       = vres.added;
                  r.audio_added       = ares.added;
                  r.table_full        = vres.full | ares.full;
                  r.slot_index        = vres.added ? vslot : (ares.added ? aslot : '0);
                end
              end
            end
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_code = VIDEO_TYPE_RST;
      audio_code = AUDIO_TYPE_RST;
      sec_kind   = SEC_IDLE;
      byte_pos   = '0;
      sec_len    = '0;
      info_len   = '0;
      skip_left  = '0;
      cur_prog   = '0;
      entry_sr   = '0;
      entry_cnt  = '0;
      video_used = '0;
      audio_used = '0;
      entry_q.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.record_kind       = psp_rec_e'(out_chan.record_kind);
        got.prog_num          = out_chan.prog_num;
        got.pid               = out_chan.pid;
        got.stream_kind       = out_chan.stream_kind;
        got.descriptor_length = out_chan.descriptor_length;
        got.video_added       = out_chan.video_added;
        got.audio_added       = out_chan.audio_added;
        got.table_full        = out_chan.table_full;
        got.slot_index        = out_chan.slot_index;
        if (entry_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = entry_q.pop_front();
          check_field("record_kind", want.record_kind, got.record_kind);
          check_field("prog_num", want.prog_num, got.prog_num);
          check_field("pid", want.pid, got.pid);
          check_field("stream_kind", want.stream_kind, got.stream_kind);
          check_field("descriptor_length", want.descriptor_length, got.descriptor_length);
          check_field("video_added", want.video_added, got.video_added);
          check_field("audio_added", want.audio_added, got.audio_added);
          check_field("table_full", want.table_full, got.table_full);
          check_field("slot_index", want.slot_index, got.slot_index);
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == CFG_VIDEO_TYPE) video_code = cfg_chan.data;
        else if (cfg_chan.index == CFG_AUDIO_TYPE) audio_code = cfg_chan.data;
      end
      if (in_chan.valid && in_chan.ready) begin
        parse_byte(in_chan.data_byte, in_chan.section_start, nxt_hit, nxt);
        if (nxt_hit) entry_q.push_back(nxt);
      end
    end
    fail_count_o <= fails;
    pending_o    <= entry_q.size();
  end

endmodule

### sim/psi_section_parser_core_tb.sv
// testbench top for psi_section_parser_core: builds pat/pmt sections and noise, drives the
// input and config channels, stalls the result channel and reports the verdict
// depends on psp_pkg, psp_chan_if, psi_section_parser_core and psp_result_checker
module psi_section_parser_core_tb;
  import psp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int IDLE_PCT     = 17;
  localparam int LONG_ENTRIES = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'hF;
  localparam logic [PID_W-1:0]     PID_POOL_BASE = 13'h0100;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   fail_total;
  int   expected_left;
  int   items_sent = 0;
  int   in_idle_pct = IDLE_PCT;
  int   out_idle_pct = IDLE_PCT;
  int   hold_req = 0;
  int   hold_done = 0;

  logic [BYTE_W-1:0] vid_code = VIDEO_TYPE_RST;
  logic [BYTE_W-1:0] aud_code = AUDIO_TYPE_RST;
  logic [BYTE_W-1:0] sec_q[$];

  always #CLK_HALF clk = ~clk;

  psp_in_chan_if  in_chan ();
  psp_out_chan_if out_chan ();
  psp_cfg_chan_if cfg_chan ();

  psi_section_parser_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  psp_result_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_chan    (cfg_chan),
    .fail_count_o(fail_total),
    .pending_o   (expected_left)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_left);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_stream();
    int r;
    r = $urandom_range(99);
    if (r < 40) return vid_code;
    if (r < 70) return aud_code;
    return rnd_byte();
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(99) < 70) return PID_POOL_BASE + PID_W'($urandom_range(11));
    return PID_W'($urandom_range(8191));
  endfunction

  function automatic logic [PROG_W-1:0] pick_prog();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PROG_W'($urandom_range(65535));
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.section_start <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic open_pat();
    sec_q.delete();
    sec_q.push_back(TID_PAT);
    sec_q.push_back(8'h00);
    sec_q.push_back(8'h00);
    repeat (5) sec_q.push_back(rnd_byte());
  endtask

  task automatic open_pmt(input logic [PROG_W-1:0] prog, input logic [LEN_W-1:0] info,
                          input int info_bytes);
    sec_q.delete();
    sec_q.push_back(TID_PMT);
    sec_q.push_back(8'h00);
    sec_q.push_back(8'h00);
    sec_q.push_back(prog[15:8]);
    sec_q.push_back(prog[7:0]);
    repeat (5) sec_q.push_back(rnd_byte());
    sec_q.push_back({4'($urandom_range(15)), info[11:8]});
    sec_q.push_back(info[7:0]);
    repeat (info_bytes) sec_q.push_back(rnd_byte());
  endtask

  task automatic add_pat_entry(input logic [PROG_W-1:0] prog, input logic [PID_W-1:0] pid);
    sec_q.push_back(prog[15:8]);
    sec_q.push_back(prog[7:0]);
    sec_q.push_back({3'($urandom_range(7)), pid[12:8]});
    sec_q.push_back(pid[7:0]);
  endtask

  task automatic add_pmt_entry(input logic [BYTE_W-1:0] st, input logic [PID_W-1:0] pid,
                               input logic [LEN_W-1:0] es, input int es_bytes);
    sec_q.push_back(st);
    sec_q.push_back({3'($urandom_range(7)), pid[12:8]});
    sec_q.push_back(pid[7:0]);
    sec_q.push_back({4'($urandom_range(15)), es[11:8]});
    sec_q.push_back(es[7:0]);
    repeat (es_bytes) sec_q.push_back(rnd_byte());
  endtask

  task automatic close_section(input bit force_len, input logic [LEN_W-1:0] forced);
    logic [LEN_W-1:0] len;
    repeat (4) sec_q.push_back(rnd_byte());
    len = force_len ? forced : LEN_W'(sec_q.size() - 3);
    sec_q[1] = {4'($urandom_range(15)), len[11:8]};
    sec_q[2] = len[7:0];
  endtask

  task automatic send_section(input int upto);
    for (int i = 0; i < sec_q.size() && i < upto; i++) send_byte(sec_q[i], i == 0);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  task automatic random_pmt();
    logic [LEN_W-1:0] info;
    logic [LEN_W-1:0] es;
    int               n;
    if ($urandom_range(9) == 0) info = LEN_W'($urandom_range(4095));
    else info = LEN_W'($urandom_range(4));
    open_pmt(pick_prog(), info, (info < 8) ? int'(info) : $urandom_range(3));
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1 && $urandom_range(9) == 0) begin
        add_pmt_entry(pick_stream(), pick_pid(), LEN_W'($urandom_range(4095)), 0);
      end else begin
        es = LEN_W'($urandom_range(3));
        add_pmt_entry(pick_stream(), pick_pid(), es, int'(es));
      end
    end
  endtask

  task automatic random_pat();
    int n;
    open_pat();
    n = $urandom_range(5);
    repeat (n) add_pat_entry(pick_prog(), PID_W'($urandom_range(8191)));
  endtask

  task automatic run_traffic(input int n_items);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if (pick < 40) random_pmt();
        else random_pat();
        if ($urandom_range(99) < 85) close_section(1'b0, '0);
        else if ($urandom_range(1) == 0) close_section(1'b1, LEN_W'($urandom_range(40)));
        else close_section(1'b1, LEN_W'($urandom_range(4095)));
        if ($urandom_range(9) == 0) send_section($urandom_range(1, sec_q.size()));
        else send_section(sec_q.size());
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 5)) send_byte(rnd_byte(), 1'b0);
      end else begin
        send_byte(rnd_byte(), 1'b1);
        repeat ($urandom_range(1, 8)) send_byte(rnd_byte(), 1'b0);
      end
    end
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] v, input logic [BYTE_W-1:0] a,
                           input int idle, input bit hold, input bit spare);
    drain();
    write_reg(CFG_VIDEO_TYPE, v);
    write_reg(CFG_AUDIO_TYPE, a);
    if (spare) write_reg(CFG_IDX_SPARE, rnd_byte());
    cfg_chan.valid <= 1'b0;
    vid_code     = v;
    aud_code     = a;
    in_idle_pct  = idle;
    out_idle_pct = idle;
    if (hold) hold_req <= hold_req + 1;
    run_traffic(PHASE_ITEMS);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.data_byte     <= '0;
    in_chan.section_start <= 1'b0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.index        <= '0;
    cfg_chan.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle byte, then an unknown table id
    send_byte(8'h55, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    open_pat();
    add_pat_entry('1, '1);
    add_pat_entry('0, '0);
    close_section(1'b0, '0);
    send_section(sec_q.size());

    // add, add, duplicate, then a descriptor run past the crc
    open_pmt('1, '0, 0);
    add_pmt_entry(vid_code, '1, '0, 0);
    add_pmt_entry(aud_code, '0, 12'd2, 2);
    add_pmt_entry(vid_code, '1, '0, 0);
    add_pmt_entry(8'hFF, 13'h0ABC, '1, 0);
    close_section(1'b0, '0);
    send_section(sec_q.size());

    // restart right after the first entry, before the second
    open_pmt(16'h1234, 12'd3, 3);
    add_pmt_entry(vid_code, 13'h0042, '0, 0);
    add_pmt_entry(aud_code, 13'h0043, '0, 0);
    close_section(1'b0, '0);
    send_section(20);

    // too short for any entry
    open_pat();
    add_pat_entry(16'h0001, 13'h0010);
    close_section(1'b1, 12'd5);
    send_section(sec_q.size());

    run_phase(8'h00, 8'hFF, IDLE_PCT, 1'b1, 1'b0);
    run_phase(8'h1B, 8'h1B, 0, 1'b0, 1'b0);
    run_phase(8'hFF, 8'h00, IDLE_PCT, 1'b0, 1'b0);
    run_phase(rnd_byte(), rnd_byte(), IDLE_PCT, 1'b0, 1'b1);
    run_phase(VIDEO_TYPE_RST, AUDIO_TYPE_RST, IDLE_PCT, 1'b0, 1'b0);

    // long pat section under the largest length field
    open_pat();
    repeat (LONG_ENTRIES) add_pat_entry(pick_prog(), PID_W'($urandom_range(8191)));
    close_section(1'b1, '1);
    send_section(sec_q.size());

    drain();
    if (fail_total == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
